// ----- rtl/core/cpc_pkg.sv -----
// Package for the coprime pair counter.
// Holds the fixed result width and the back-to-front status type; no dependencies.
`default_nettype none
package cpc_pkg;

  localparam int PAIR_BITS = 39;

  typedef logic [PAIR_BITS-1:0] pair_t;

  typedef struct packed {
    logic clear_done;
    logic busy;
  } back_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/cpc_if.sv -----
// Valid/ready channel interfaces of the coprime pair counter.
// Depends on cpc_pkg for the result width.
`default_nettype none
interface cpc_in_if #(
  parameter int VALUE_BITS = 20
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface cpc_out_if
  import cpc_pkg::*;
();
  logic  valid;
  logic  ready;
  pair_t coprime_pairs;
  logic  saturated;

  modport source (output valid, output coprime_pairs, output saturated, input ready);
  modport sink (input valid, input coprime_pairs, input saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/coprime_pair_counter_top.sv -----
// Top level of the coprime pair counter.
// Instantiates cpc_factor, cpc_queue and cpc_subset; depends on cpc_pkg and cpc_if.
//
// Use: send one positive value per transfer on in_i; each transfer yields one
// transfer on out_o carrying the running number of coprime pairs among all
// values so far and a sticky saturation flag. A zero value changes nothing
// and reports the current totals.
// Operation: the front factors by trial division, one quotient bit a cycle,
// after it strips the factors of two. The back then walks each of the 2^n-1
// prime subsets of an n-prime value: product, memory read, memory write.
// Overlap: a two-entry queue lets the front factor the next value while the
// back updates the count memory.
// Reset: asynchronous, active low. Afterwards the back clears all 2^VALUE_BITS
// count memory entries one entry a cycle, and in_i.ready stays low meanwhile.
// Stall: a result waits in the output register; the back holds its finished
// item while that register is occupied, and the queue then the front.
`default_nettype none
module coprime_pair_counter_top
  import cpc_pkg::*;
#(
  parameter int VALUE_BITS = 20,
  parameter int MAX_PRIMES = 7,
  parameter int COUNT_BITS = 21
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpc_in_if.sink    in_i,
  cpc_out_if.source out_o
);

  localparam int NW    = $clog2(MAX_PRIMES + 1);
  localparam int JOB_W = 1 + NW + MAX_PRIMES * VALUE_BITS;

  // front to queue
  logic             f_valid, f_ready;
  logic [JOB_W-1:0] f_job;
  // queue to back
  logic             b_valid, b_ready;
  logic [JOB_W-1:0] b_job;
  back_status_t     status;

  // factor values, held off until the count memory is cleared
  cpc_factor #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_PRIMES (MAX_PRIMES)
  ) u_factor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (status.clear_done),
    .in_i        (in_i),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  // decouple the two halves
  cpc_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_job),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_job)
  );

  // inclusion-exclusion over subsets and the running totals
  cpc_subset #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_PRIMES (MAX_PRIMES),
    .COUNT_BITS (COUNT_BITS)
  ) u_subset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_i       (b_job),
    .status_o    (status),
    .out_o       (out_o)
  );

  // no input is taken while the memory is being cleared
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> status.clear_done)
    else $error("input ready during memory clear");

  // no result can appear before the clear pass ends
  a_no_result_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> status.clear_done)
    else $error("result during memory clear");

  // the back works on one item at a time
  a_back_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid && b_ready) |=> (!b_ready && status.busy))
    else $error("back took a second item while busy");

endmodule
`default_nettype wire

// ----- rtl/core/cpc_factor.sv -----
// Front part: accepts values and finds their distinct primes by trial division.
// Uses a bit-serial restoring divider; depends on cpc_if.
`default_nettype none
module cpc_factor #(
  parameter int VALUE_BITS = 20,
  parameter int MAX_PRIMES = 7,
  localparam int NW    = $clog2(MAX_PRIMES + 1),
  localparam int JOB_W = 1 + NW + MAX_PRIMES * VALUE_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  cpc_in_if.sink                in_i,
  output      logic             job_valid_o,
  input  wire logic             job_ready_i,
  output      logic [JOB_W-1:0] job_o
);

  localparam int PW = (VALUE_BITS + 1) / 2 + 2;
  localparam int CW = $clog2(VALUE_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TWO  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]            st_q, st_d;
  logic [VALUE_BITS-1:0] x_q, x_d;
  logic [PW-1:0]         p_q, p_d;
  logic [NW-1:0]         n_q, n_d;
  logic [VALUE_BITS-1:0] primes_q [MAX_PRIMES];
  logic [VALUE_BITS-1:0] primes_d [MAX_PRIMES];
  logic                  found_q, found_d;
  logic                  skip_q, skip_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [PW-1:0]         rem_q, rem_d;
  logic [CW-1:0]         cnt_q, cnt_d;

  logic [2*PW-1:0]       pp;
  logic [PW:0]           trial;
  logic                  ge;

  assign in_i.ready  = (st_q == S_IDLE) && en_i;
  assign job_valid_o = (st_q == S_DONE);

  assign pp    = p_q * p_q;
  assign trial = {rem_q, x_q[cnt_q]};
  assign ge    = (trial >= {1'b0, p_q});

  always_comb begin
    job_o = '0;
    for (int i = 0; i < MAX_PRIMES; i++) begin
      job_o[i*VALUE_BITS +: VALUE_BITS] = primes_q[i];
    end
    job_o[MAX_PRIMES*VALUE_BITS +: NW] = n_q;
    job_o[JOB_W-1]                     = skip_q;
  end

  always_comb begin
    st_d     = st_q;
    x_d      = x_q;
    p_d      = p_q;
    n_d      = n_q;
    primes_d = primes_q;
    found_d  = found_q;
    skip_d   = skip_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    case (st_q)
      S_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          x_d     = in_i.value;
          n_d     = '0;
          found_d = 1'b0;
          skip_d  = (in_i.value == '0);
          p_d     = PW'(3);
          if (in_i.value == '0) begin
            st_d = S_DONE;
          end else if (!in_i.value[0]) begin
            primes_d[0] = VALUE_BITS'(2);
            n_d         = NW'(1);
            st_d        = S_TWO;
          end else begin
            st_d = S_CHK;
          end
        end
      end
      S_TWO: begin
        // strip factors of two one bit a cycle
        if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else begin
          st_d = S_CHK;
        end
      end
      S_CHK: begin
        if (pp > {{(2*PW-VALUE_BITS){1'b0}}, x_q}) begin
          // remaining cofactor is prime
          if (x_q != VALUE_BITS'(1) && n_q < NW'(MAX_PRIMES)) begin
            for (int i = 0; i < MAX_PRIMES; i++) begin
              if (NW'(i) == n_q) primes_d[i] = x_q;
            end
            n_d = n_q + NW'(1);
          end
          st_d = S_DONE;
        end else begin
          quo_d = '0;
          rem_d = '0;
          cnt_d = CW'(VALUE_BITS - 1);
          st_d  = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = ge ? PW'(trial - {1'b0, p_q}) : trial[PW-1:0];
        quo_d = {quo_q[VALUE_BITS-2:0], ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          if (rem_d == '0) begin
            // divisible: record once, divide out and try again
            if (!found_q && n_q < NW'(MAX_PRIMES)) begin
              for (int i = 0; i < MAX_PRIMES; i++) begin
                if (NW'(i) == n_q) primes_d[i] = {{(VALUE_BITS-PW){1'b0}}, p_q};
              end
              n_d = n_q + NW'(1);
            end
            found_d = 1'b1;
            x_d     = quo_d;
            quo_d   = '0;
            rem_d   = '0;
            cnt_d   = CW'(VALUE_BITS - 1);
          end else begin
            p_d     = p_q + PW'(2);
            found_d = 1'b0;
            st_d    = S_CHK;
          end
        end
      end
      S_DONE: begin
        if (job_ready_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    p_q      <= p_d;
    n_q      <= n_d;
    primes_q <= primes_d;
    found_q  <= found_d;
    skip_q   <= skip_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
  end

endmodule
`default_nettype wire

// ----- rtl/core/cpc_queue.sv -----
// Two-entry queue between the front and back parts.
// Standalone; payload is an opaque vector.
`default_nettype none
module cpc_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output      logic             wr_ready_o,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output      logic             rd_valid_o,
  input  wire logic             rd_ready_i,
  output      logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule
`default_nettype wire

// ----- rtl/core/cpc_subset.sv -----
// Back part: walks prime subsets, updates the divisor count memory, sums pairs.
// Depends on cpc_pkg and cpc_if.
`default_nettype none
module cpc_subset
  import cpc_pkg::*;
#(
  parameter int VALUE_BITS = 20,
  parameter int MAX_PRIMES = 7,
  parameter int COUNT_BITS = 21,
  localparam int NW    = $clog2(MAX_PRIMES + 1),
  localparam int JOB_W = 1 + NW + MAX_PRIMES * VALUE_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  output      logic             job_ready_o,
  input  wire logic [JOB_W-1:0] job_i,
  output      back_status_t     status_o,
  cpc_out_if.source             out_o
);

  localparam int IW    = $clog2(MAX_PRIMES);
  localparam int MW    = MAX_PRIMES + 1;
  localparam int SUMW  = (COUNT_BITS + MAX_PRIMES > PAIR_BITS) ?
                         COUNT_BITS + MAX_PRIMES : PAIR_BITS;
  localparam int ACC_W = SUMW + 3;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [COUNT_BITS-1:0] tab_q [2**VALUE_BITS];
  logic [COUNT_BITS-1:0] rd_q;

  logic [2:0]              st_q, st_d;
  logic [VALUE_BITS-1:0]   clr_q, clr_d;
  logic [VALUE_BITS-1:0]   primes_q [MAX_PRIMES];
  logic [VALUE_BITS-1:0]   primes_d [MAX_PRIMES];
  logic [NW-1:0]           n_q, n_d;
  logic                    skip_q, skip_d;
  logic [MW-1:0]           mask_q, mask_d;
  logic [NW-1:0]           j_q, j_d;
  logic [VALUE_BITS-1:0]   d_q, d_d;
  logic                    odd_q, odd_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [COUNT_BITS-1:0]   items_q, items_d;
  pair_t                   pair_q, pair_d;
  logic                    sat_q, sat_d;
  logic                    ov_q, ov_d;
  pair_t                   opair_q, opair_d;
  logic                    osat_q, osat_d;

  logic                    we;
  logic [VALUE_BITS-1:0]   wa;
  logic [COUNT_BITS-1:0]   wd;
  logic [2*VALUE_BITS-1:0] prod;
  logic signed [ACC_W-1:0] entry_s;
  logic [MW-1:0]           mask_nx;

  assign job_ready_o         = (st_q == S_IDLE);
  assign status_o.clear_done = (st_q != S_CLR);
  assign status_o.busy       = (st_q != S_IDLE) && (st_q != S_CLR);

  assign out_o.valid         = ov_q;
  assign out_o.coprime_pairs = opair_q;
  assign out_o.saturated     = osat_q;

  assign prod    = d_q * primes_q[j_q[IW-1:0]];
  assign entry_s = $signed({{(ACC_W-COUNT_BITS){1'b0}}, rd_q});
  assign mask_nx = mask_q + MW'(1);

  always_comb begin
    st_d     = st_q;
    clr_d    = clr_q;
    primes_d = primes_q;
    n_d      = n_q;
    skip_d   = skip_q;
    mask_d   = mask_q;
    j_d      = j_q;
    d_d      = d_q;
    odd_d    = odd_q;
    acc_d    = acc_q;
    items_d  = items_q;
    pair_d   = pair_q;
    sat_d    = sat_q;
    ov_d     = ov_q;
    opair_d  = opair_q;
    osat_d   = osat_q;
    we       = 1'b0;
    wa       = d_q;
    wd       = '0;

    if (ov_q && out_o.ready) ov_d = 1'b0;

    case (st_q)
      S_CLR: begin
        we    = 1'b1;
        wa    = clr_q;
        clr_d = clr_q + VALUE_BITS'(1);
        if (clr_q == '1) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (job_valid_i) begin
          for (int i = 0; i < MAX_PRIMES; i++) begin
            primes_d[i] = job_i[i*VALUE_BITS +: VALUE_BITS];
          end
          n_d    = job_i[MAX_PRIMES*VALUE_BITS +: NW];
          skip_d = job_i[JOB_W-1];
          acc_d  = $signed({{(ACC_W-PAIR_BITS){1'b0}}, pair_q}) +
                   $signed({{(ACC_W-COUNT_BITS){1'b0}}, items_q});
          mask_d = MW'(1);
          j_d    = '0;
          d_d    = VALUE_BITS'(1);
          odd_d  = 1'b0;
          if (job_i[JOB_W-1] || job_i[MAX_PRIMES*VALUE_BITS +: NW] == '0) begin
            st_d = S_FIN;
          end else begin
            st_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        // build the subset product one prime a cycle
        if (mask_q[j_q]) begin
          d_d   = prod[VALUE_BITS-1:0];
          odd_d = ~odd_q;
        end
        j_d = j_q + NW'(1);
        if (j_q == n_q - NW'(1)) st_d = S_RD;
      end
      S_RD: begin
        st_d = S_UPD;
      end
      S_UPD: begin
        acc_d = odd_q ? acc_q - entry_s : acc_q + entry_s;
        we    = 1'b1;
        wa    = d_q;
        if (rd_q == '1) begin
          wd    = rd_q;
          sat_d = 1'b1;
        end else begin
          wd = rd_q + COUNT_BITS'(1);
        end
        mask_d = mask_nx;
        j_d    = '0;
        d_d    = VALUE_BITS'(1);
        odd_d  = 1'b0;
        if (mask_nx == (MW'(1) << n_q)) begin
          st_d = S_FIN;
        end else begin
          st_d = S_MUL;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!ov_q || out_o.ready) begin
          if (!skip_q) begin
            if (items_q == '1) begin
              sat_d = 1'b1;
            end else begin
              items_d = items_q + COUNT_BITS'(1);
            end
            if (acc_q < 0) begin
              pair_d = '0;
            end else if (acc_q > $signed({{(ACC_W-PAIR_BITS){1'b0}}, {PAIR_BITS{1'b1}}})) begin
              pair_d = '1;
              sat_d  = 1'b1;
            end else begin
              pair_d = acc_q[PAIR_BITS-1:0];
            end
          end
          ov_d    = 1'b1;
          opair_d = pair_d;
          osat_d  = sat_d;
          st_d    = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_CLR;
      clr_q   <= '0;
      items_q <= '0;
      pair_q  <= '0;
      sat_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      clr_q   <= clr_d;
      items_q <= items_d;
      pair_q  <= pair_d;
      sat_q   <= sat_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    primes_q <= primes_d;
    n_q      <= n_d;
    skip_q   <= skip_d;
    mask_q   <= mask_d;
    j_q      <= j_d;
    d_q      <= d_d;
    odd_q    <= odd_d;
    acc_q    <= acc_d;
    opair_q  <= opair_d;
    osat_q   <= osat_d;
  end

  // count memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) tab_q[wa] <= wd;
    rd_q <= tab_q[d_q];
  end

endmodule
`default_nettype wire

// ----- bench/cpc_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the coprime pair counter: watches both channels, predicts
// each result and compares it. Depends on cpc_pkg and the cpc_if interfaces.
`default_nettype none
module cpc_checker
  import cpc_pkg::*;
#(
  parameter int VALUE_BITS = 20,
  parameter int MAX_PRIMES = 7,
  parameter int COUNT_BITS = 21
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpc_in_if         in_mon,
  cpc_out_if        out_mon,
  output int        errors_o,
  output int        pending_o
);

  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam longint          PAIR_MAX  = (64'sd1 << PAIR_BITS) - 1;

  typedef struct {
    pair_t pairs;
    logic  sat;
  } tally_t;

  tally_t                 tally_q[$];
  longint unsigned        multiple_cnt[int];
  longint unsigned        values_seen;
  longint                 pair_sum;
  logic                   sat_flag;
  int                     mismatches;

  assign errors_o = mismatches;

  // Update the running totals for one value and return the new tally.
  function automatic tally_t count_coprime(input logic [VALUE_BITS-1:0] v);
    longint unsigned rest, p, d;
    longint unsigned primes[$];
    longint          acc;
    int              k;
    tally_t          t;
    if (v != '0) begin
      rest = v;
      if (rest[0] == 1'b0) begin
        while (rest[0] == 1'b0) rest = rest >> 1;
        primes = {primes, 64'd2};
      end
      for (p = 3; p * p <= rest; p += 2) begin
        if (rest % p == 0) begin
          while (rest % p == 0) rest = rest / p;
          if (primes.size() < MAX_PRIMES) primes = {primes, p};
        end
      end
      if (rest != 1 && primes.size() < MAX_PRIMES) primes = {primes, rest};
      acc = longint'(values_seen);
      for (int m = 1; m < (1 << primes.size()); m++) begin
        d = 1;
        k = 0;
        for (int j = 0; j < primes.size(); j++) begin
          if (m[j]) begin
            d = d * primes[j];
            k++;
          end
        end
        d = d & ((64'd1 << VALUE_BITS) - 1);
        if (!multiple_cnt.exists(int'(d))) multiple_cnt[int'(d)] = 0;
        if (k % 2 == 1) acc -= longint'(multiple_cnt[int'(d)]);
        else acc += longint'(multiple_cnt[int'(d)]);
        if (multiple_cnt[int'(d)] < COUNT_MAX) multiple_cnt[int'(d)]++;
        else sat_flag = 1'b1;
      end
      if (values_seen < COUNT_MAX) values_seen++;
      else sat_flag = 1'b1;
      acc += pair_sum;
      if (acc < 0) acc = 0;
      if (acc > PAIR_MAX) begin
        acc = PAIR_MAX;
        sat_flag = 1'b1;
      end
      pair_sum = acc;
    end
    t.pairs = pair_t'(pair_sum);
    t.sat   = sat_flag;
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    if (!rst_ni) begin
      tally_q.delete();
      multiple_cnt.delete();
      values_seen = 0;
      pair_sum    = 0;
      sat_flag    = 1'b0;
      mismatches  = 0;
      pending_o   = 0;
    end else begin
      // Compare first: a result can never belong to a value taken this cycle.
      if (out_mon.valid && out_mon.ready) begin
        if (tally_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result pairs=%0d sat=%0b", $realtime,
                     out_mon.coprime_pairs, out_mon.saturated);
        end else begin
          want = tally_q.pop_front();
          if (out_mon.coprime_pairs !== want.pairs || out_mon.saturated !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch pairs exp=%0d act=%0d sat exp=%0b act=%0b",
                       $realtime, want.pairs, out_mon.coprime_pairs, want.sat,
                       out_mon.saturated);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) tally_q = {tally_q, count_coprime(in_mon.value)};
      pending_o = tally_q.size();
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_coprime_pair_counter_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the coprime pair counter: drives values, paces the
// result channel and gives the verdict. Depends on cpc_pkg, cpc_if, cpc_checker.
`default_nettype none
module tb_coprime_pair_counter_top;
  import cpc_pkg::*;

  localparam int VALUE_BITS = 20;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_off_req;
  int   errors;
  int   pending;

  cpc_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  cpc_out_if out_ch ();

  coprime_pair_counter_top #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  cpc_checker #(.VALUE_BITS(VALUE_BITS)) checker_u (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up well past the slowest legal run: the memory clear after reset plus
  // every value at its worst factoring time and stalls.
  initial begin
    #80_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Pace the result channel. A hold-off request keeps ready low for a long
  // stretch so the queue inside fills and back-pressure reaches the input.
  initial begin
    int hold_cnt;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req && hold_cnt == 0) hold_cnt = 60000;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one value and hold it until the transfer. Valid drops only when a
  // gap is taken, so back-to-back transfers never lower and raise it in one step.
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Mostly cheap values: small ones or smooth products of small primes, which
  // exercise many prime subsets while keeping trial division short. A few span
  // the full range so every value bit toggles.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned sel, v, p;
    int unsigned small_primes[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
    sel = $urandom_range(99);
    if (sel < 45) return VALUE_BITS'($urandom_range(4095, 1));
    if (sel < 85) begin
      v = 1;
      repeat ($urandom_range(8, 1)) begin
        p = small_primes[$urandom_range(10)];
        if (v * p < (1 << VALUE_BITS)) v = v * p;
      end
      return VALUE_BITS'(v);
    end
    if (sel < 90) return '0;
    return VALUE_BITS'($urandom_range((1 << VALUE_BITS) - 1, 1));
  endfunction

  initial begin
    logic [VALUE_BITS-1:0] directed[$];
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    hold_off_req  = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 83;
    rst_n         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Zero (ignored), one (coprime with all), the top value, a large prime,
    // the densest squarefree value, powers and repeats of shared factors.
    directed = '{0, 1, 1, 2, 4, 3, 6, 30, 210, 2310, 30030, 510510,
                 524288, 531441, 1048575, 1048573, 999983, 0, 1, 510510,
                 15, 77, 1024, 9, 1048574};
    foreach (directed[i]) send_value(directed[i]);
    repeat (20) send_value(pick_value());

    // Swap the idle rates.
    send_idle_pct = 83;
    recv_idle_pct = 19;
    repeat (25) send_value(pick_value());

    // No idling; start with a long receiver hold-off while values keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_ch.valid  <= 1'b0;
    hold_off_req <= 1'b1;
    @(posedge clk);
    hold_off_req <= 1'b0;
    repeat (30) send_value(pick_value());
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
